/* sv/heightmap_triangle_sampler_macros.svh */
// Assertion macros shared by the height sampler RTL.
// No dependencies; included by modules that carry assertions.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLER_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLER_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define HTS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hts assertion failed");

// Condition that must never hold out of reset.
`define HTS_ASSERT_NEVER(name, clk, rstn, cond) \
  `HTS_ASSERT(name, clk, rstn, !(cond))

`endif

/* sv/hts_pkg.sv */
// Package for the height sampler: sequencer states, codes and constants.
// No dependencies.
package hts_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_IDX,
    ST_READ,
    ST_SCALE,
    ST_ZADD,
    ST_LSUB,
    ST_LMUL,
    ST_LADD,
    ST_DONE
  } state_e;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z     = 3'd2;
  localparam logic [2:0] REG_SCALE_X      = 3'd3;
  localparam logic [2:0] REG_SCALE_Y      = 3'd4;
  localparam logic [2:0] REG_HEIGHT_SCALE = 3'd5;

  localparam logic [31:0] Q16_ONE = 32'h0001_0000;
  localparam logic [16:0] FRAC_ONE = 17'h1_0000;

endpackage

/* sv/hts_if.sv */
// Valid/ready channel interfaces for the height sampler request and result.
// No dependencies.
interface hts_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic        [7:0]  write_col;
  logic        [7:0]  write_row;
  logic        [15:0] write_height;

  modport source (output valid, op, world_x, world_y, write_col, write_row, write_height,
                  input ready);
  modport sink   (input valid, op, world_x, world_y, write_col, write_row, write_height,
                  output ready);
endinterface

interface hts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height;
  logic               clamped;
  logic               saturated;

  modport source (output valid, height, clamped, saturated, input ready);
  modport sink   (input valid, height, clamped, saturated, output ready);
endinterface

/* sv/hts_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module hts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/heightmap_triangle_sampler.sv */
// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------
// in_i      in   op, world_x, world_y, write_col, write_row, write_height
// out_o     out  height, clamped, saturated (one beat per query)
// apb       in   origin_x/y/z, scale_x/y, height_scale at 4*index
//
// Write beat: stored in the accept cycle, block ready again next cycle.
// Query beat: MULX, MULY, IDX, corner fetches, blends; DONE loads the output
//   register and returns to IDLE, where the next beat is taken. The single RAM read port
//   fetches the four corners one by one (read, scale multiply, offset add); one
//   shared lerp unit runs three blends (subtract, partial products, add).
// Reset: async, active low; clears control and config, not the sample store.
// A result waiting in the output register stalls only the next finished query.
// Depends on hts_pkg, hts_if, hts_ram and the macros header.
`include "heightmap_triangle_sampler_macros.svh"

module heightmap_triangle_sampler import hts_pkg::*; #(
  parameter int GRID_COLS_LOG2 = 8,
  parameter int GRID_ROWS_LOG2 = 8,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hts_in_if.sink      in_i,
  hts_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = GRID_COLS_LOG2 + GRID_ROWS_LOG2;
  localparam int DEPTH = 1 << AW;
  // Corner Z: unsigned sample*scale plus signed offset
  localparam int ZW = SAMPLE_BITS + 34;
  localparam int DW = ZW + 1;
  localparam int HW = DW - 32;
  localparam int PW = DW + 16;
  localparam logic signed [33:0] COL_MAX = 34'((1 << GRID_COLS_LOG2) - 1);
  localparam logic signed [33:0] ROW_MAX = 34'((1 << GRID_ROWS_LOG2) - 1);

  // ---------------- configuration ----------------
  logic [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic [31:0] scale_x_q, scale_y_q, height_scale_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      origin_z_q     <= '0;
      scale_x_q      <= Q16_ONE;
      scale_y_q      <= Q16_ONE;
      height_scale_q <= Q16_ONE;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ORIGIN_X:     origin_x_q     <= pwdata;
        REG_ORIGIN_Y:     origin_y_q     <= pwdata;
        REG_ORIGIN_Z:     origin_z_q     <= pwdata;
        REG_SCALE_X:      scale_x_q      <= pwdata;
        REG_SCALE_Y:      scale_y_q      <= pwdata;
        REG_HEIGHT_SCALE: height_scale_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X:     prdata = origin_x_q;
      REG_ORIGIN_Y:     prdata = origin_y_q;
      REG_ORIGIN_Z:     prdata = origin_z_q;
      REG_SCALE_X:      prdata = scale_x_q;
      REG_SCALE_Y:      prdata = scale_y_q;
      REG_HEIGHT_SCALE: prdata = height_scale_q;
      default:          prdata = '0;
    endcase
  end

  // ---------------- control state ----------------
  state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;     // corner being fetched
  logic [1:0] lcnt_q, lcnt_d;   // blend step
  logic       out_valid_q, out_valid_d;

  logic in_fire, wr_inrange, ram_we, out_load;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign in_fire = in_i.valid && in_i.ready;
  assign wr_inrange = ((32'(in_i.write_col) >> GRID_COLS_LOG2) == 32'd0) &&
                      ((32'(in_i.write_row) >> GRID_ROWS_LOG2) == 32'd0);

  // ---------------- datapath registers ----------------
  logic signed [31:0] wx_q, wy_q;
  logic signed [65:0] px_q, py_q;
  logic [GRID_COLS_LOG2-1:0] c0_q, c1_q;
  logic [GRID_ROWS_LOG2-1:0] r0_q, r1_q;
  logic [15:0] fi_q, fj_q;
  logic        lower_q, clamped_q;
  logic [SAMPLE_BITS+31:0] zprod_q;
  logic signed [ZW-1:0] h0_q, h1_q, h2_q, h3_q, e0_q, e1_q, res_q;
  logic signed [DW-1:0] d_q;
  logic [47:0] pplo_q;
  logic signed [HW+16:0] pphi_q;

  // to_cell products: (world - origin) * scale, exact
  logic signed [32:0] dx, dy;
  logic signed [65:0] mul_x, mul_y;
  assign dx = 33'(wx_q) - 33'($signed(origin_x_q));
  assign dy = 33'(wy_q) - 33'($signed(origin_y_q));
  assign mul_x = dx * $signed({1'b0, scale_x_q});
  assign mul_y = dy * $signed({1'b0, scale_y_q});

  // Cell index is the integer part of the Q34.32 local coordinate
  logic signed [33:0] idx_i, idx_i1, idx_j, idx_j1;
  logic [GRID_COLS_LOG2-1:0] c0_d, c1_d;
  logic [GRID_ROWS_LOG2-1:0] r0_d, r1_d;
  logic cl_c0, cl_c1, cl_r0, cl_r1;

  assign idx_i  = $signed(px_q[65:32]);
  assign idx_j  = $signed(py_q[65:32]);
  assign idx_i1 = idx_i + 34'sd1;
  assign idx_j1 = idx_j + 34'sd1;

  always_comb begin
    cl_c0 = (idx_i < 0) || (idx_i > COL_MAX);
    cl_c1 = (idx_i1 < 0) || (idx_i1 > COL_MAX);
    cl_r0 = (idx_j < 0) || (idx_j > ROW_MAX);
    cl_r1 = (idx_j1 < 0) || (idx_j1 > ROW_MAX);
    c0_d = (idx_i < 0) ? '0 : (idx_i > COL_MAX) ? '1 : idx_i[GRID_COLS_LOG2-1:0];
    c1_d = (idx_i1 < 0) ? '0 : (idx_i1 > COL_MAX) ? '1 : idx_i1[GRID_COLS_LOG2-1:0];
    r0_d = (idx_j < 0) ? '0 : (idx_j > ROW_MAX) ? '1 : idx_j[GRID_ROWS_LOG2-1:0];
    r1_d = (idx_j1 < 0) ? '0 : (idx_j1 > ROW_MAX) ? '1 : idx_j1[GRID_ROWS_LOG2-1:0];
  end

  // Corner fetch order: (I,J) (I,J+1) (I+1,J) (I+1,J+1)
  logic [GRID_COLS_LOG2-1:0] rd_col;
  logic [GRID_ROWS_LOG2-1:0] rd_row;
  assign rd_col = cnt_q[1] ? c1_q : c0_q;
  assign rd_row = cnt_q[0] ? r1_q : r0_q;

  logic signed [ZW-1:0] z_sum;
  assign z_sum = $signed({2'b00, zprod_q}) + ZW'($signed(origin_z_q));

  // Shared lerp unit: a + floor((b - a) * f / 2^16)
  logic signed [ZW-1:0] la, lb;
  logic [15:0] lf;
  always_comb begin
    case (lcnt_q)
      2'd0: begin
        la = lower_q ? h0_q : h2_q;
        lb = h1_q;
        lf = fj_q;
      end
      2'd1: begin
        la = h2_q;
        lb = lower_q ? h1_q : h3_q;
        lf = fj_q;
      end
      default: begin
        la = e0_q;
        lb = e1_q;
        lf = fi_q;
      end
    endcase
  end

  logic signed [PW-1:0] lprod;
  logic signed [DW-1:0] lsum;
  assign lprod = (PW'(pphi_q) <<< 32) + $signed(PW'(pplo_q));
  assign lsum  = DW'(la) + $signed(lprod[PW-1:16]);

  // Saturation to Q16.16
  logic sat_hi, sat_lo;
  logic [31:0] height_d;
  assign sat_hi = res_q > $signed(ZW'(32'h7FFF_FFFF));
  assign sat_lo = res_q < ZW'($signed(32'h8000_0000));
  assign height_d = sat_hi ? 32'h7FFF_FFFF : sat_lo ? 32'h8000_0000 : res_q[31:0];

  logic [31:0] out_height_q;
  logic        out_clamped_q, out_sat_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lcnt_d  = lcnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.op == OP_QUERY)) state_d = ST_MULX;
      end
      ST_MULX: state_d = ST_MULY;
      ST_MULY: state_d = ST_IDX;
      ST_IDX: begin
        state_d = ST_READ;
        cnt_d   = 2'd0;
      end
      ST_READ:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_ZADD;
      ST_ZADD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_LSUB;
          lcnt_d  = 2'd0;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_LSUB: state_d = ST_LMUL;
      ST_LMUL: state_d = ST_LADD;
      ST_LADD: begin
        lcnt_d = lcnt_q + 2'd1;
        state_d = (lcnt_q == 2'd2) ? ST_DONE : ST_LSUB;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = AW'({rd_row, rd_col});
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_we     = in_fire && (in_i.op == OP_WRITE) && wr_inrange;
      end
      ST_DONE: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign ram_waddr = (AW'(in_i.write_row) << GRID_COLS_LOG2) | AW'(in_i.write_col);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 2'd0;
      lcnt_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lcnt_q      <= lcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, loaded per sequencer step
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        wx_q <= in_i.world_x;
        wy_q <= in_i.world_y;
      end
      ST_MULX: px_q <= mul_x;
      ST_MULY: py_q <= mul_y;
      ST_IDX: begin
        c0_q      <= c0_d;
        c1_q      <= c1_d;
        r0_q      <= r0_d;
        r1_q      <= r1_d;
        fi_q      <= px_q[31:16];
        fj_q      <= py_q[31:16];
        lower_q   <= ({1'b0, px_q[31:16]} + {1'b0, py_q[31:16]}) < FRAC_ONE;
        clamped_q <= cl_c0 || cl_c1 || cl_r0 || cl_r1;
      end
      ST_SCALE: zprod_q <= ram_rdata * height_scale_q;
      ST_ZADD: begin
        case (cnt_q)
          2'd0:    h0_q <= z_sum;
          2'd1:    h1_q <= z_sum;
          2'd2:    h2_q <= z_sum;
          default: h3_q <= z_sum;
        endcase
      end
      ST_LSUB: d_q <= DW'(lb) - DW'(la);
      ST_LMUL: begin
        pplo_q <= d_q[31:0] * lf;
        pphi_q <= $signed(d_q[DW-1:32]) * $signed({1'b0, lf});
      end
      ST_LADD: begin
        case (lcnt_q)
          2'd0:    e0_q  <= lsum[ZW-1:0];
          2'd1:    e1_q  <= lsum[ZW-1:0];
          default: res_q <= lsum[ZW-1:0];
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      out_height_q  <= height_d;
      out_clamped_q <= clamped_q;
      out_sat_q     <= sat_hi || sat_lo;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.height    = out_height_q;
  assign out_o.clamped   = out_clamped_q;
  assign out_o.saturated = out_sat_q;

  // Sample store; writes only in idle, read data used only mid-query, so no overlap
  hts_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (SAMPLE_BITS'(in_i.write_height)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `HTS_ASSERT(a_we_idle, clk_i, rst_ni, ram_we |-> (state_q == ST_IDLE))
  `HTS_ASSERT(a_query_starts, clk_i, rst_ni, (in_fire && in_i.op == OP_QUERY) |=> (state_q == ST_MULX))
  `HTS_ASSERT(a_done_holds, clk_i, rst_ni, (state_q == ST_DONE && out_valid_q && !out_o.ready) |=> (state_q == ST_DONE))
  `HTS_ASSERT(a_sat_limit, clk_i, rst_ni, (out_valid_q && out_sat_q) |-> (out_height_q == 32'h7FFF_FFFF || out_height_q == 32'h8000_0000))

endmodule
